@@ rtl/core/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared codes, reset values and beat types of the register sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// Command modes
	localparam logic [1:0] MODE_BEGIN_WR = 2'd0;
	localparam logic [1:0] MODE_BEGIN_RD = 2'd1;
	localparam logic [1:0] MODE_DATA     = 2'd2;
	localparam logic [1:0] MODE_POLL     = 2'd3;

	// Actions toward the bus engine and the requester
	localparam logic [2:0] ACT_START  = 3'd0;
	localparam logic [2:0] ACT_SEND   = 3'd1;
	localparam logic [2:0] ACT_RSTART = 3'd2;
	localparam logic [2:0] ACT_STOP   = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;
	localparam logic [2:0] ACT_WANT   = 3'd5;
	localparam logic [2:0] ACT_DONE   = 3'd6;

	// Completion status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_PARAM   = 2'd3;

	// Configuration space
	localparam int          PADDR_W       = 3;
	localparam logic [0:0]  REG_TIMEOUT   = 1'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd50000;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] dev_address;
		logic [7:0] reg_address;
		logic       use_register;
		logic [7:0] byte_count;
		logic [7:0] data_byte;
		logic       tx_ready;
		logic       rx_ready;
		logic       nack_seen;
		logic       start_pending;
		logic       stop_pending;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] slave_address;
		logic [7:0] byte_out;
		logic [1:0] status;
		logic       last;
	} result_t;

	// Up to two result beats produced by one command beat.
	typedef struct packed {
		logic       valid;
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

endpackage

@@ rtl/core/i2cms_if.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer channels
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [6:0] dev_address;
	logic [7:0] reg_address;
	logic       use_register;
	logic [7:0] byte_count;
	logic [7:0] data_byte;
	logic       tx_ready;
	logic       rx_ready;
	logic       nack_seen;
	logic       start_pending;
	logic       stop_pending;

	modport source (
		output valid, mode, dev_address, reg_address, use_register, byte_count,
		       data_byte, tx_ready, rx_ready, nack_seen, start_pending, stop_pending,
		input  ready
	);
	modport sink (
		input  valid, mode, dev_address, reg_address, use_register, byte_count,
		       data_byte, tx_ready, rx_ready, nack_seen, start_pending, stop_pending,
		output ready
	);
endinterface

interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [6:0] slave_address;
	logic [7:0] byte_out;
	logic [1:0] status;
	logic       last;

	modport source (
		output valid, action, slave_address, byte_out, status, last,
		input  ready
	);
	modport sink (
		input  valid, action, slave_address, byte_out, status, last,
		output ready
	);
endinterface

@@ rtl/core/i2c_master_register_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master register sequencer
// Turns register read/write commands and bus-status polls into a stream of
// byte-level bus engine actions and completion reports.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   -------  ---------  ---------------------------------------------------
//   cmd      in         mode, addresses, byte count, data byte, engine flags
//   res      out        action, slave address, byte, status, last marker
//   APB      in/out     timeout_limit at byte address 0 (16 bits used)
//
// Every command beat is captured in the input register; once the result
// buffer can take its beats, a single state transition produces zero, one or
// two result beats into the result buffer. A new command beat is taken each
// cycle as long as the result buffer drains; a step that yields two beats holds
// the command side until its first beat has left. The empty input register can
// take a command while a result still waits on res.ready, but the step stalls.
// After arst_n releases the sequencer is idle and the limit reads 50000.
//
// Transaction flow: a begin command emits a start; polls then walk through
// the register byte, data bytes pulled with "want data", the repeated start
// for reads and the closing stop. A NACK or an exhausted poll count emits a
// stop followed by done with an error status.
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer
	import i2cms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	i2cms_cmd_if.sink          cmd,
	i2cms_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] timeout_limit;
	logic        out_free;
	res_pair_t   pair;

	// Configuration register file.
	i2cms_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.timeout_limit(timeout_limit)
	);

	// Input register and transaction state machine. The state only moves
	// when the result buffer can take the beats of the step.
	i2cms_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.timeout_limit(timeout_limit),
		.out_free     (out_free),
		.pair         (pair)
	);

	// Result buffer, which serializes the beats of one step onto res.
	i2cms_out_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair    (pair),
		.out_free(out_free),
		.res     (res)
	);

endmodule

@@ rtl/core/i2cms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer configuration registers
// APB-style write/read access to the poll timeout limit.
// ----------------------------------------------------------------------------
module i2cms_cfg_regs
	import i2cms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [15:0]        timeout_limit
);

	logic       sel_timeout;
	logic [15:0] limit_q;

	assign pready      = 1'b1;
	assign sel_timeout = (paddr[PADDR_W-1:2] == REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && sel_timeout) begin
			limit_q <= pwdata[15:0];
		end
	end

	assign prdata        = sel_timeout ? {16'd0, limit_q} : 32'd0;
	assign timeout_limit = limit_q;

endmodule

@@ rtl/core/i2cms_step.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer step unit
// Input register, transaction state and the state transition of each step.
// ----------------------------------------------------------------------------
module i2cms_step
	import i2cms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cms_cmd_if.sink   cmd,
	input  logic [15:0] timeout_limit,
	input  logic        out_free,
	output res_pair_t   pair
);

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_TX_WAIT     = 3'd1;
	localparam logic [2:0] PH_WANT_DATA   = 3'd2;
	localparam logic [2:0] PH_RSTART_WAIT = 3'd3;
	localparam logic [2:0] PH_RX_WAIT     = 3'd4;
	localparam logic [2:0] PH_STOP_WAIT   = 3'd5;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        advance;

	logic [2:0]  phase_q,    phase_d;
	logic        is_read_q,  is_read_d;
	logic        send_reg_q, send_reg_d;
	logic [7:0]  saved_reg_q, saved_reg_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [15:0] poll_q,     poll_d;

	logic [15:0] lim;
	logic        timeout_hit;
	logic [1:0]  n;
	result_t     r0, r1;

	function automatic result_t mk(logic [2:0] act, logic [6:0] addr,
	                               logic [7:0] dat, logic [1:0] st);
		result_t r;
		r.action        = act;
		r.slave_address = addr;
		r.byte_out      = dat;
		r.status        = st;
		r.last          = 1'b0;
		return r;
	endfunction

	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= '{mode: cmd.mode, dev_address: cmd.dev_address,
			            reg_address: cmd.reg_address, use_register: cmd.use_register,
			            byte_count: cmd.byte_count, data_byte: cmd.data_byte,
			            tx_ready: cmd.tx_ready, rx_ready: cmd.rx_ready,
			            nack_seen: cmd.nack_seen, start_pending: cmd.start_pending,
			            stop_pending: cmd.stop_pending};
		end
	end

	// A zero limit behaves as a limit of one.
	assign lim         = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
	assign timeout_hit = ({1'b0, poll_q} + 17'd1) >= {1'b0, lim};

	always_comb begin
		phase_d      = phase_q;
		is_read_d    = is_read_q;
		send_reg_d   = send_reg_q;
		saved_reg_d  = saved_reg_q;
		bytes_left_d = bytes_left_q;
		poll_d       = poll_q;
		n            = 2'd0;
		r0           = mk(ACT_DONE, 7'd0, 8'd0, ST_OK);
		r1           = mk(ACT_DONE, 7'd0, 8'd0, ST_OK);

		case (cmd_s1.mode)
			MODE_BEGIN_WR, MODE_BEGIN_RD: begin
				if (phase_q == PH_IDLE) begin
					if (cmd_s1.byte_count == 8'd0) begin
						r0 = mk(ACT_DONE, 7'd0, 8'd0, ST_PARAM);
						n  = 2'd1;
					end else if (!cmd_s1.stop_pending) begin
						is_read_d    = (cmd_s1.mode == MODE_BEGIN_RD);
						send_reg_d   = (cmd_s1.mode == MODE_BEGIN_RD) || cmd_s1.use_register;
						saved_reg_d  = cmd_s1.reg_address;
						bytes_left_d = cmd_s1.byte_count;
						poll_d       = 16'd0;
						phase_d      = PH_TX_WAIT;
						r0           = mk(ACT_START, cmd_s1.dev_address, 8'd0, ST_OK);
						n            = 2'd1;
					end
				end
			end
			MODE_DATA: begin
				if (phase_q == PH_WANT_DATA) begin
					r0           = mk(ACT_SEND, 7'd0, cmd_s1.data_byte, ST_OK);
					n            = 2'd1;
					bytes_left_d = bytes_left_q - 8'd1;
					poll_d       = 16'd0;
					phase_d      = PH_TX_WAIT;
				end
			end
			default: begin
				case (phase_q)
					PH_TX_WAIT, PH_RX_WAIT: begin
						if ((phase_q == PH_TX_WAIT && !cmd_s1.tx_ready) ||
						    (phase_q == PH_RX_WAIT && !cmd_s1.rx_ready)) begin
							// Unanswered poll: a NACK wins over the timeout count.
							if (cmd_s1.nack_seen || timeout_hit) begin
								r0      = mk(ACT_STOP, 7'd0, 8'd0, ST_OK);
								r1      = mk(ACT_DONE, 7'd0, 8'd0,
								             cmd_s1.nack_seen ? ST_NACK : ST_TIMEOUT);
								n       = 2'd2;
								phase_d = PH_IDLE;
							end else begin
								poll_d = poll_q + 16'd1;
							end
						end else if (phase_q == PH_TX_WAIT) begin
							poll_d = 16'd0;
							n      = 2'd1;
							if (send_reg_q) begin
								send_reg_d = 1'b0;
								r0         = mk(ACT_SEND, 7'd0, saved_reg_q, ST_OK);
							end else if (is_read_q) begin
								phase_d = PH_RSTART_WAIT;
								r0      = mk(ACT_RSTART, 7'd0, 8'd0, ST_OK);
							end else if (bytes_left_q != 8'd0) begin
								phase_d = PH_WANT_DATA;
								r0      = mk(ACT_WANT, 7'd0, 8'd0, ST_OK);
							end else begin
								phase_d = PH_STOP_WAIT;
								r0      = mk(ACT_STOP, 7'd0, 8'd0, ST_OK);
							end
						end else begin
							poll_d       = 16'd0;
							bytes_left_d = bytes_left_q - 8'd1;
							r0           = mk(ACT_READ, 7'd0, cmd_s1.data_byte, ST_OK);
							n            = 2'd1;
							if (bytes_left_q == 8'd2) begin
								r1 = mk(ACT_STOP, 7'd0, 8'd0, ST_OK);
								n  = 2'd2;
							end else if (bytes_left_q == 8'd1) begin
								phase_d = PH_STOP_WAIT;
							end
						end
					end
					PH_RSTART_WAIT: begin
						if (cmd_s1.start_pending) begin
							if (cmd_s1.nack_seen) begin
								r0      = mk(ACT_STOP, 7'd0, 8'd0, ST_OK);
								r1      = mk(ACT_DONE, 7'd0, 8'd0, ST_NACK);
								n       = 2'd2;
								phase_d = PH_IDLE;
							end
						end else begin
							poll_d  = 16'd0;
							phase_d = PH_RX_WAIT;
							if (bytes_left_q <= 8'd1) begin
								r0 = mk(ACT_STOP, 7'd0, 8'd0, ST_OK);
								n  = 2'd1;
							end
						end
					end
					PH_STOP_WAIT: begin
						if (!cmd_s1.stop_pending) begin
							phase_d = PH_IDLE;
							r0      = mk(ACT_DONE, 7'd0, 8'd0, ST_OK);
							n       = 2'd1;
						end
					end
					PH_IDLE, PH_WANT_DATA: begin
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		endcase

		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			is_read_q    <= 1'b0;
			send_reg_q   <= 1'b0;
			saved_reg_q  <= 8'd0;
			bytes_left_q <= 8'd0;
			poll_q       <= 16'd0;
		end else if (advance) begin
			phase_q      <= phase_d;
			is_read_q    <= is_read_d;
			send_reg_q   <= send_reg_d;
			saved_reg_q  <= saved_reg_d;
			bytes_left_q <= bytes_left_d;
			poll_q       <= poll_d;
		end
	end

	assign pair = '{valid: advance, count: n, r0: r0, r1: r1};

endmodule

@@ rtl/core/i2cms_out_buf.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer result buffer
// Holds the one or two result beats of a step and hands them out in order.
// ----------------------------------------------------------------------------
module i2cms_out_buf
	import i2cms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_pair_t  pair,
	output logic       out_free,
	i2cms_res_if.source res
);

	logic [1:0] cnt_q;
	result_t    r0_s2, r1_s2;
	logic       pop;

	assign pop      = res.valid && res.ready;
	assign out_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (pair.valid) begin
			cnt_q <= pair.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid) begin
			r0_s2 <= pair.r0;
			r1_s2 <= pair.r1;
		end else if (pop) begin
			r0_s2 <= r1_s2;
		end
	end

	assign res.valid         = (cnt_q != 2'd0);
	assign res.action        = r0_s2.action;
	assign res.slave_address = r0_s2.slave_address;
	assign res.byte_out      = r0_s2.byte_out;
	assign res.status        = r0_s2.status;
	assign res.last          = r0_s2.last;

endmodule

@@ rtl/core/i2cms_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker
	import i2cms_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [2:0]         action,
	input logic [6:0]         slave_address,
	input logic [1:0]         status,
	input logic               last,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata
);

	// A stalled result beat stays up with the same contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(action) && $stable(status)
		&& $stable(last) && $stable(slave_address))
		else $error("result beat changed while stalled");

	// Done always closes the beats of a command.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && action == ACT_DONE |-> last)
		else $error("done beat without last marker");

	// Status and address only travel with done and start respectively.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (action == ACT_DONE || status == ST_OK)
		&& (action == ACT_START || slave_address == 7'd0))
		else $error("status or address set on the wrong action");

	// A written limit reads back on the following cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == '0 |=>
		paddr != '0 || prdata == {16'd0, $past(pwdata[15:0])})
		else $error("timeout limit readback mismatch");

endmodule

bind i2c_master_register_sequencer i2cms_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.action       (res.action),
	.slave_address(res.slave_address),
	.status       (res.status),
	.last         (res.last),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);
